// ===== hw/rtl/lrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrd_pkg
// Shared types, constants and helpers of the log record deframer.
// ----------------------------------------------------------------------------
package lrd_pkg;

  localparam int MAX_REC_LEN = 32;
  localparam int WIN_DEPTH   = MAX_REC_LEN + 1;
  localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
  localparam int WIDX_W      = $clog2(WIN_DEPTH);

  localparam logic [5:0]  SEP_LEN       = 6'd5;
  localparam logic [11:0] HDR_RESET     = 12'h400;
  localparam logic [31:0] MAGIC_RESET   = 32'h5AFECA5E;
  localparam logic [7:0]  MAX_ID        = 8'd6;

  typedef enum logic [2:0] {
    REG_HEADER   = 3'd0,
    REG_MAGIC    = 3'd1,
    REG_LEN_TS   = 3'd2,
    REG_LEN_IMU  = 3'd3,
    REG_LEN_PID  = 3'd4,
    REG_LEN_PAR  = 3'd5,
    REG_LEN_GPS  = 3'd6,
    REG_LEN_QUAT = 3'd7
  } lrd_reg_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_SKIP   = 2'd2,
    KIND_TRUNC  = 2'd3
  } lrd_kind_t;

  typedef enum logic {
    ST_WAIT = 1'b0,
    ST_RUN  = 1'b1
  } lrd_state_t;

  typedef enum logic [2:0] {
    ACT_FINISH,
    ACT_HDR,
    ACT_REC,
    ACT_SKIP,
    ACT_CLR_RESYNC,
    ACT_OPEN
  } lrd_act_t;

  typedef struct packed {
    logic [11:0] header_bytes;
    logic [31:0] magic_word;
    logic [5:0]  len_ts;
    logic [5:0]  len_imu;
    logic [5:0]  len_pid;
    logic [5:0]  len_par;
    logic [5:0]  len_gps;
    logic [5:0]  len_quat;
  } lrd_cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    lrd_kind_t  byte_kind;
    logic [2:0] rec_type;
    logic [4:0] byte_index;
    logic       first_of_record;
    logic       last_of_record;
    logic       last_of_run;
  } lrd_res_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } lrd_item_t;

  // Total length of a record type, clamped to 1..MAX_REC_LEN
  function automatic logic [5:0] type_len(input logic [2:0] id, input lrd_cfg_t c);
    logic [5:0] l;
    case (id)
      3'd0:    l = SEP_LEN;
      3'd1:    l = c.len_ts;
      3'd2:    l = c.len_imu;
      3'd3:    l = c.len_pid;
      3'd4:    l = c.len_par;
      3'd5:    l = c.len_gps;
      3'd6:    l = c.len_quat;
      default: l = 6'd1;
    endcase
    if (l == 6'd0) l = 6'd1;
    if (l > 6'(MAX_REC_LEN)) l = 6'(MAX_REC_LEN);
    return l;
  endfunction

endpackage

// ===== hw/rtl/lrd_in_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrd_in_queue
// Two-entry request queue between the stream input and the parse engine.
// ----------------------------------------------------------------------------
module lrd_in_queue
  import lrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  lrd_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      avail,
  output lrd_item_t head
);

  lrd_item_t   mem [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = mem[rptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Store requests
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("input queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !avail |-> !pop) else $error("input queue underflow");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && count == 2'd1) |=> full) else $error("input queue count");
`endif

endmodule

// ===== hw/rtl/lrd_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrd_out_queue
// Two-entry result queue that drives the stream output.
// ----------------------------------------------------------------------------
module lrd_out_queue
  import lrd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  lrd_res_t push_res,
  output logic     full,
  output logic     avail,
  input  logic     pop,
  output lrd_res_t head
);

  lrd_res_t   mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = mem[rptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_res;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("output queue overflow");
  a_hold_head: assert property (@(posedge clk) disable iff (rst)
    (avail && !pop) |=> avail && $stable(head)) else $error("output head moved");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !avail |-> !pop) else $error("output queue underflow");
`endif

endmodule

// ===== hw/rtl/lrd_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrd_engine
// Lookahead window and record parser: one parse step per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module lrd_engine
  import lrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  lrd_cfg_t  cfg,
  input  logic      hdr_wr,
  input  logic [11:0] hdr_value,
  input  logic      in_avail,
  input  lrd_item_t in_item,
  output logic      in_pop,
  input  logic      out_full,
  output logic      out_push,
  output lrd_res_t  out_res
);

  lrd_state_t  state;
  lrd_state_t  state_next;
  logic [7:0]  win [WIN_DEPTH];
  logic [FILL_W-1:0] fill;
  logic [11:0] header_left;
  logic [5:0]  bytes_left;
  logic [2:0]  cur_type;
  logic [4:0]  cur_index;
  logic        resyncing;
  logic        rec_trunc;
  logic        idle;
  logic        end_flag;
  logic        pend_valid;
  lrd_res_t    pend;

  logic        go;
  lrd_act_t    act;
  logic [7:0]  b;
  logic [5:0]  blen;
  logic [7:0]  tap;
  logic        magic_known;
  logic        magic_ok;
  logic        emit;
  logic        load;
  lrd_res_t    new_res;
  logic [2:0]  open_type;
  logic        open_trunc;
  logic [FILL_W-1:0] fill_base;
  logic [FILL_W-1:0] fill_load;

  assign go          = (state == ST_RUN) && !out_full;
  assign b           = win[0];
  assign blen        = type_len(b[2:0], cfg);
  assign tap         = win[WIDX_W'(blen)];
  assign magic_known = fill >= FILL_W'(SEP_LEN);
  assign magic_ok    = {win[4], win[3], win[2], win[1]} == cfg.magic_word;

  // Pick the parse step for the byte at the window head
  always_comb begin
    act        = ACT_FINISH;
    open_type  = b[2:0];
    open_trunc = 1'b0;
    if (fill == '0) begin
      act = ACT_FINISH;
    end else if (header_left != 12'd0) begin
      act = ACT_HDR;
    end else if (bytes_left != 6'd0) begin
      act = ACT_REC;
    end else if (resyncing) begin
      if (b == 8'd0) begin
        if (!magic_known) act = end_flag ? ACT_SKIP : ACT_FINISH;
        else              act = magic_ok ? ACT_CLR_RESYNC : ACT_SKIP;
      end else if (b <= MAX_ID) begin
        if (fill <= FILL_W'(blen)) act = end_flag ? ACT_SKIP : ACT_FINISH;
        else act = (tap <= MAX_ID) ? ACT_CLR_RESYNC : ACT_SKIP;
      end else begin
        act = ACT_SKIP;
      end
    end else if (b == 8'd0) begin
      if (!magic_known) act = end_flag ? ACT_SKIP : ACT_FINISH;
      else              act = magic_ok ? ACT_OPEN : ACT_SKIP;
    end else if (b <= MAX_ID) begin
      if (fill >= FILL_W'(blen)) begin
        act = ACT_OPEN;
      end else if (end_flag) begin
        act        = ACT_OPEN;
        open_trunc = 1'b1;
      end else begin
        act = ACT_FINISH;
      end
    end else begin
      act = ACT_SKIP;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_WAIT: if (in_avail) state_next = ST_RUN;
      ST_RUN:  if (go && act == ACT_FINISH && !in_avail) state_next = ST_WAIT;
      default: state_next = ST_WAIT;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    emit     = go && (act == ACT_HDR || act == ACT_REC || act == ACT_SKIP);
    load     = in_avail && ((state == ST_WAIT) || (go && act == ACT_FINISH));
    in_pop   = load;
    out_push = pend_valid && (emit || (go && act == ACT_FINISH));
    out_res  = pend;
    out_res.last_of_run = (act == ACT_FINISH);

    new_res = '{out_byte: b, byte_kind: KIND_SKIP, rec_type: 3'd0, byte_index: 5'd0,
                first_of_record: 1'b0, last_of_record: 1'b0, last_of_run: 1'b0};
    case (act)
      ACT_HDR: new_res.byte_kind = KIND_HEADER;
      ACT_REC: begin
        new_res.byte_kind       = rec_trunc ? KIND_TRUNC : KIND_RECORD;
        new_res.rec_type        = cur_type;
        new_res.byte_index      = cur_index;
        new_res.first_of_record = (cur_index == 5'd0);
        new_res.last_of_record  = !rec_trunc && (bytes_left == 6'd1);
      end
      default: new_res.byte_kind = KIND_SKIP;
    endcase

    fill_base = (go && act == ACT_FINISH && end_flag) ? '0 : fill;
    fill_load = (fill_base == FILL_W'(WIN_DEPTH)) ? fill_base : fill_base + 1'b1;
  end

  // Hold the state machine
  always_ff @(posedge clk) begin
    if (rst) state <= ST_WAIT;
    else     state <= state_next;
  end

  // Advance parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      header_left <= HDR_RESET;
      bytes_left  <= 6'd0;
      cur_type    <= 3'd0;
      cur_index   <= 5'd0;
      resyncing   <= 1'b0;
      rec_trunc   <= 1'b0;
      idle        <= 1'b1;
      end_flag    <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      if (hdr_wr && idle) header_left <= hdr_value;
      if (go) begin
        case (act)
          ACT_HDR: header_left <= header_left - 12'd1;
          ACT_REC: begin
            bytes_left <= bytes_left - 6'd1;
            cur_index  <= cur_index + 5'd1;
          end
          ACT_SKIP:       resyncing <= 1'b1;
          ACT_CLR_RESYNC: resyncing <= 1'b0;
          ACT_OPEN: begin
            cur_type   <= open_type;
            cur_index  <= 5'd0;
            bytes_left <= blen;
            rec_trunc  <= open_trunc;
          end
          ACT_FINISH: begin
            pend_valid <= 1'b0;
            // Start a new stream after the final byte
            if (end_flag) begin
              header_left <= cfg.header_bytes;
              bytes_left  <= 6'd0;
              cur_type    <= 3'd0;
              cur_index   <= 5'd0;
              resyncing   <= 1'b0;
              rec_trunc   <= 1'b0;
              // A byte loaded in this cycle already belongs to the next stream
              if (!load) begin
                idle <= 1'b1;
                fill <= '0;
              end
            end
          end
          default: ;
        endcase
        if (emit) begin
          fill       <= fill - 1'b1;
          pend_valid <= 1'b1;
        end
      end
      if (load) begin
        fill     <= fill_load;
        end_flag <= in_item.stream_end;
        idle     <= 1'b0;
      end
    end
  end

  // Shift and fill the window, stage the pending result
  always_ff @(posedge clk) begin
    if (emit) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) win[i] <= win[i + 1];
      pend <= new_res;
    end
    if (load) win[WIDX_W'(fill_load - 1'b1)] <= in_item.in_byte;
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WIN_DEPTH)) else $error("window overfilled");
  a_hdr_rec_excl: assert property (@(posedge clk) disable iff (rst)
    !(header_left != 12'd0 && bytes_left != 6'd0)) else $error("header inside record");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full) else $error("result pushed into full queue");
  a_load_no_emit: assert property (@(posedge clk) disable iff (rst)
    load |-> !emit) else $error("window load during shift");
`endif

endmodule

// ===== hw/rtl/log_record_deframer_with_resync.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_record_deframer_with_resync
// Splits a logged byte stream into header, typed records and skipped bytes.
// ----------------------------------------------------------------------------
// Each input byte enters a 33-byte lookahead window; the parse engine then
// takes one parse step per cycle while the result queue has room (pass a
// header byte, pass a record byte, skip a byte, or open/resync a record)
// until the window head needs more lookahead, and tags each byte leaving the
// window. The results a byte releases leave by shift steps, followed by a
// wait step that also loads the next byte when one is queued; each record
// opened and each resync cleared on the way takes a step of its own in the
// single-step engine. A two-entry input queue and a two-entry result queue
// let input and output stall independently.
// tlast on the output marks the last result released by one input byte.
// Write configuration only while no stream byte is in flight.
module log_record_deframer_with_resync
  import lrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // stream_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [10:8] rec_type, [15:11] byte_index,
                                 // [16] first_of_record, [17] last_of_record, zero above
  output logic [1:0]  m_tuser,   // [1:0] byte_kind
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  lrd_cfg_t  cfg;
  logic      hdr_wr;
  logic      in_full;
  logic      in_avail;
  logic      in_pop;
  lrd_item_t in_head;
  logic      out_full;
  logic      out_avail;
  logic      out_push;
  lrd_res_t  out_res;
  lrd_res_t  out_head;

  assign cfg_ready = 1'b1;
  assign hdr_wr    = cfg_valid && (lrd_reg_t'(cfg_index) == REG_HEADER);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_bytes <= HDR_RESET;
      cfg.magic_word   <= MAGIC_RESET;
      cfg.len_ts       <= 6'd5;
      cfg.len_imu      <= 6'd17;
      cfg.len_pid      <= 6'd17;
      cfg.len_par      <= 6'd18;
      cfg.len_gps      <= 6'd30;
      cfg.len_quat     <= 6'd13;
    end else if (cfg_valid) begin
      case (lrd_reg_t'(cfg_index))
        REG_HEADER:   cfg.header_bytes <= cfg_data[11:0];
        REG_MAGIC:    cfg.magic_word   <= cfg_data;
        REG_LEN_TS:   cfg.len_ts       <= cfg_data[5:0];
        REG_LEN_IMU:  cfg.len_imu      <= cfg_data[5:0];
        REG_LEN_PID:  cfg.len_pid      <= cfg_data[5:0];
        REG_LEN_PAR:  cfg.len_par      <= cfg_data[5:0];
        REG_LEN_GPS:  cfg.len_gps      <= cfg_data[5:0];
        REG_LEN_QUAT: cfg.len_quat     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !in_full;

  lrd_in_queue u_in_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && !in_full),
    .push_item ('{in_byte: s_tdata, stream_end: s_tlast}),
    .full      (in_full),
    .pop       (in_pop),
    .avail     (in_avail),
    .head      (in_head)
  );

  lrd_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .hdr_wr    (hdr_wr),
    .hdr_value (cfg_data[11:0]),
    .in_avail  (in_avail),
    .in_item   (in_head),
    .in_pop    (in_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_res   (out_res)
  );

  lrd_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (out_push),
    .push_res (out_res),
    .full     (out_full),
    .avail    (out_avail),
    .pop      (out_avail && m_tready),
    .head     (out_head)
  );

  // Pack the result onto the output stream
  assign m_tvalid = out_avail;
  assign m_tdata  = {6'd0, out_head.last_of_record, out_head.first_of_record,
                     out_head.byte_index, out_head.rec_type, out_head.out_byte};
  assign m_tuser  = out_head.byte_kind;
  assign m_tlast  = out_head.last_of_run;

endmodule
